### sv/kcs_pkg.sv
// kcs_pkg: shared constants, command and status types for the lattice coefficient search
// used by kcs_divider, kcs_datapath, kcs_ctrl and korobov_coefficient_search
package kcs_pkg;

  localparam int MAX_DIM   = 20;
  localparam int MOD_BITS  = 16;
  localparam int FRAC_BITS = 31;
  localparam int DIM_W     = 5;
  localparam int NODE_W    = 2 * MOD_BITS;
  localparam int PROD_W    = 2 * NODE_W;
  localparam int SUM_W     = 63;
  localparam int CFG_IDX_W = 2;

  localparam logic [NODE_W-1:0] Q_ONE  = NODE_W'(64'd1 << FRAC_BITS);
  localparam logic [PROD_W-1:0] Q_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [PROD_W-1:0] SUM_MAX = {1'b0, {(PROD_W-1){1'b1}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_P_MODULUS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_MODULUS  = 2'd2;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_DIV_ARED,
    OP_TAKE_ARED,
    OP_CAND_FIRST,
    OP_GEN_INIT,
    OP_GEN_A,
    OP_GEN_B,
    OP_DIV_PP,
    OP_TAKE_PP,
    OP_DIV_PQ,
    OP_TAKE_PQ,
    OP_J_NEXT,
    OP_MERIT_INIT,
    OP_TERM_INIT,
    OP_RES,
    OP_NUM,
    OP_DIV_FM,
    OP_MUL_A,
    OP_MUL_B,
    OP_SQ_A,
    OP_SQ_B,
    OP_TERM_INC,
    OP_CONSIDER,
    OP_CAND_INC,
    OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic search_ok;
    logic kind;
    logic dim_last;
    logic term_last;
    logic cand_last;
    logic div_busy;
  } status_t;

endpackage

### sv/korobov_coefficient_search.sv
// korobov_coefficient_search: top level of the lattice coefficient search
// depends on kcs_pkg, kcs_ctrl, kcs_datapath (which holds kcs_divider)
//
//   channel   handshake            payload
//   cfg       cfg_wen              cfg_index, cfg_data
//   in        in_valid/in_ready    kind, a_coef
//   out       out_valid/out_ready  best_coef, best_sum
//
// one request runs a whole search; each dimension of each term waits on the
// shared restoring divider, as do the generator powers of each dimension of
// each candidate, once for an a search and twice for a b search
// rst is synchronous; the tables need no clearing pass
// the result sits in an output register, so a new request may be taken
// while the previous result waits for out_ready
module korobov_coefficient_search (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [kcs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kcs_pkg::MOD_BITS-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic [kcs_pkg::MOD_BITS-1:0]         a_coef,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [kcs_pkg::MOD_BITS-1:0]         best_coef,
  output logic [kcs_pkg::SUM_W-1:0]            best_sum
);

  kcs_pkg::cmd_t    cmd;
  kcs_pkg::status_t status;

  kcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  kcs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kind      (kind),
    .a_coef    (a_coef),
    .cmd       (cmd),
    .status    (status),
    .best_coef (best_coef),
    .best_sum  (best_sum)
  );

endmodule

### sv/kcs_divider.sv
// kcs_divider: restoring divider, one quotient bit per cycle
// depends on kcs_pkg; upper half of the dividend must be below the divisor
module kcs_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [kcs_pkg::PROD_W-1:0]        dividend,
  input  logic [kcs_pkg::NODE_W-1:0]        divisor,
  output logic                              busy,
  output logic [kcs_pkg::NODE_W-1:0]        quotient,
  output logic [kcs_pkg::NODE_W-1:0]        remainder
);

  localparam int CNT_W = $clog2(kcs_pkg::NODE_W + 1);

  logic [kcs_pkg::NODE_W-1:0] rem;
  logic [kcs_pkg::NODE_W-1:0] quo;
  logic [kcs_pkg::NODE_W-1:0] dvs;
  logic [CNT_W-1:0]           count;
  logic [kcs_pkg::NODE_W:0]   trial;
  logic                       fits;

  // one shift and subtract step
  assign trial = {rem, quo[kcs_pkg::NODE_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(kcs_pkg::NODE_W);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[kcs_pkg::PROD_W-1:kcs_pkg::NODE_W];
      quo <= dividend[kcs_pkg::NODE_W-1:0];
      dvs <= divisor;
    end else if (count != '0) begin
      rem <= fits ? kcs_pkg::NODE_W'(trial - {1'b0, dvs}) : trial[kcs_pkg::NODE_W-1:0];
      quo <= {quo[kcs_pkg::NODE_W-2:0], fits};
    end
  end

  assign busy      = count != '0;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

### sv/kcs_datapath.sv
// kcs_datapath: configuration, generator and residue tables, shared multiplier, merit sum
// depends on kcs_pkg and kcs_divider
module kcs_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [kcs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kcs_pkg::MOD_BITS-1:0]         cfg_data,
  input  logic                                 kind,
  input  logic [kcs_pkg::MOD_BITS-1:0]         a_coef,
  input  kcs_pkg::cmd_t                        cmd,
  output kcs_pkg::status_t                     status,
  output logic [kcs_pkg::MOD_BITS-1:0]         best_coef,
  output logic [kcs_pkg::SUM_W-1:0]            best_sum
);

  localparam int NW = kcs_pkg::NODE_W;
  localparam int MB = kcs_pkg::MOD_BITS;
  localparam int PW = kcs_pkg::PROD_W;

  // configuration
  logic [kcs_pkg::DIM_W-1:0] dimensions;
  logic [MB-1:0]             p_modulus;
  logic [MB-1:0]             q_modulus;

  // per-search state
  logic                      kind_reg;
  logic                      search_ok;
  logic [MB-1:0]             a_coef_reg;
  logic [MB-1:0]             a_red;
  logic [kcs_pkg::DIM_W-1:0] dim_last;
  logic [NW-1:0]             node_count;
  logic [NW-1:0]             term_count;
  logic [MB-1:0]             cand_end;
  logic [MB-1:0]             candidate;
  logic [MB-1:0]             power_p;
  logic [MB-1:0]             power_q;
  logic [kcs_pkg::DIM_W-1:0] dim_idx;
  logic [NW-1:0]             gen_step [kcs_pkg::MAX_DIM];
  logic [NW-1:0]             residue [kcs_pkg::MAX_DIM];
  logic [NW-1:0]             gen_part;
  logic [NW-1:0]             r_val;
  logic [NW-1:0]             num;
  logic                      first_term;
  logic [NW-1:0]             term_index;
  logic [NW-1:0]             mag;
  logic                      neg;
  logic [PW-1:0]             prod_reg;
  logic [PW-1:0]             sum_acc;
  logic [PW-1:0]             best_sum_reg;
  logic [MB-1:0]             best_coef_reg;

  // shared multiplier and divider
  logic [NW-1:0]             mul_a;
  logic [NW-1:0]             mul_b;
  logic [PW-1:0]             prod;
  logic                      div_start;
  logic [PW-1:0]             div_dividend;
  logic [NW-1:0]             div_divisor;
  logic                      div_busy;
  logic [NW-1:0]             div_quo;
  logic [NW-1:0]             div_rem;

  // combinational helpers
  logic [MB-1:0]             p_half;
  logic [kcs_pkg::DIM_W-1:0] dim_clamped;
  logic [NW:0]               gen_sum;
  logic [NW-1:0]             r_prev;
  logic [NW:0]               r_sum;
  logic [NW:0]               two_r;
  logic [PW-1:0]             rounded;

  assign p_half = (p_modulus - 1'b1) >> 1;

  always_comb begin
    if (dimensions == '0) begin
      dim_clamped = kcs_pkg::DIM_W'(1);
    end else if (dimensions > kcs_pkg::DIM_W'(kcs_pkg::MAX_DIM)) begin
      dim_clamped = kcs_pkg::DIM_W'(kcs_pkg::MAX_DIM);
    end else begin
      dim_clamped = dimensions;
    end
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      kcs_pkg::OP_START: begin
        mul_a = NW'(p_modulus);
        mul_b = NW'(q_modulus);
      end
      kcs_pkg::OP_GEN_A: begin
        mul_a = NW'(power_q);
        mul_b = NW'(p_modulus);
      end
      kcs_pkg::OP_GEN_B: begin
        mul_a = NW'(power_p);
        mul_b = NW'(q_modulus);
      end
      kcs_pkg::OP_DIV_PP: begin
        mul_a = NW'(power_p);
        mul_b = kind_reg ? NW'(a_red) : NW'(candidate);
      end
      kcs_pkg::OP_DIV_PQ: begin
        mul_a = NW'(power_q);
        mul_b = NW'(candidate);
      end
      kcs_pkg::OP_MUL_A: begin
        mul_a = mag;
        mul_b = div_quo;
      end
      kcs_pkg::OP_SQ_A: begin
        mul_a = mag;
        mul_b = mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // divider operand selection
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = NW'(p_modulus);
    case (cmd.op)
      kcs_pkg::OP_DIV_ARED: begin
        div_start    = 1'b1;
        div_dividend = PW'(a_coef_reg);
      end
      kcs_pkg::OP_DIV_PP: begin
        div_start    = 1'b1;
        div_dividend = prod;
      end
      kcs_pkg::OP_DIV_PQ: begin
        div_start    = 1'b1;
        div_dividend = prod;
        div_divisor  = NW'(q_modulus);
      end
      kcs_pkg::OP_DIV_FM: begin
        div_start    = 1'b1;
        div_dividend = (PW'(num) << kcs_pkg::FRAC_BITS) + PW'(node_count >> 1);
        div_divisor  = node_count;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  kcs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign gen_sum = {1'b0, gen_part} + {1'b0, prod[NW-1:0]};
  assign r_prev  = first_term ? {NW{1'b0}} : residue[dim_idx];
  assign r_sum   = {1'b0, r_prev} + {1'b0, gen_step[dim_idx]};
  assign two_r   = {r_val, 1'b0};
  assign rounded = (prod_reg + kcs_pkg::Q_HALF) >> kcs_pkg::FRAC_BITS;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions <= kcs_pkg::DIM_W'(1);
      p_modulus  <= MB'(1);
      q_modulus  <= MB'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        kcs_pkg::CFG_DIMENSIONS: dimensions <= cfg_data[kcs_pkg::DIM_W-1:0];
        kcs_pkg::CFG_P_MODULUS:  p_modulus  <= cfg_data;
        kcs_pkg::CFG_Q_MODULUS:  q_modulus  <= cfg_data;
        default: ;
      endcase
    end
  end

  // search state, executed one operation per cycle
  always_ff @(posedge clk) begin
    case (cmd.op)
      kcs_pkg::OP_START: begin
        kind_reg      <= kind;
        a_coef_reg    <= a_coef;
        dim_last      <= dim_clamped - 1'b1;
        node_count    <= kind ? prod[NW-1:0] : NW'(p_modulus);
        term_count    <= kind ? prod[NW-1:0] : NW'(p_half);
        cand_end      <= kind ? q_modulus - 1'b1 : p_half;
        search_ok     <= kind ? (p_modulus != '0 && q_modulus >= MB'(2))
                              : (p_modulus >= MB'(3));
        best_sum_reg  <= '1;
        best_coef_reg <= '0;
      end
      kcs_pkg::OP_TAKE_ARED: a_red <= div_rem[MB-1:0];
      kcs_pkg::OP_CAND_FIRST: candidate <= MB'(1);
      kcs_pkg::OP_GEN_INIT: begin
        power_p <= (p_modulus == MB'(1)) ? '0 : MB'(1);
        power_q <= (q_modulus == MB'(1)) ? '0 : MB'(1);
        dim_idx <= '0;
      end
      kcs_pkg::OP_GEN_A: begin
        if (kind_reg) begin
          gen_part <= prod[NW-1:0];
        end else begin
          gen_step[dim_idx] <= NW'(power_p);
        end
      end
      kcs_pkg::OP_GEN_B: begin
        gen_step[dim_idx] <= (gen_sum >= {1'b0, node_count})
                             ? NW'(gen_sum - {1'b0, node_count}) : gen_sum[NW-1:0];
      end
      kcs_pkg::OP_TAKE_PP: power_p <= div_rem[MB-1:0];
      kcs_pkg::OP_TAKE_PQ: power_q <= div_rem[MB-1:0];
      kcs_pkg::OP_J_NEXT: dim_idx <= dim_idx + 1'b1;
      kcs_pkg::OP_MERIT_INIT: begin
        sum_acc    <= '0;
        term_index <= NW'(1);
        first_term <= 1'b1;
      end
      kcs_pkg::OP_TERM_INIT: begin
        mag     <= kcs_pkg::Q_ONE;
        neg     <= 1'b0;
        dim_idx <= '0;
      end
      // step the residue of this dimension
      kcs_pkg::OP_RES: begin
        r_val <= (r_sum >= {1'b0, node_count})
                 ? NW'(r_sum - {1'b0, node_count}) : r_sum[NW-1:0];
        residue[dim_idx] <= (r_sum >= {1'b0, node_count})
                            ? NW'(r_sum - {1'b0, node_count}) : r_sum[NW-1:0];
      end
      // magnitude and sign of n - 2r
      kcs_pkg::OP_NUM: begin
        if (two_r <= {1'b0, node_count}) begin
          num <= NW'({1'b0, node_count} - two_r);
        end else begin
          num <= NW'(two_r - {1'b0, node_count});
          neg <= ~neg;
        end
      end
      kcs_pkg::OP_MUL_A: prod_reg <= prod;
      kcs_pkg::OP_MUL_B: mag <= rounded[NW-1:0];
      kcs_pkg::OP_SQ_A: prod_reg <= prod;
      // saturating accumulate of the squared product
      kcs_pkg::OP_SQ_B: begin
        sum_acc    <= (sum_acc > kcs_pkg::SUM_MAX - rounded) ? kcs_pkg::SUM_MAX
                                                             : sum_acc + rounded;
        first_term <= 1'b0;
      end
      kcs_pkg::OP_TERM_INC: term_index <= term_index + 1'b1;
      kcs_pkg::OP_CONSIDER: begin
        if (sum_acc < best_sum_reg) begin
          best_sum_reg  <= sum_acc;
          best_coef_reg <= candidate;
        end
      end
      kcs_pkg::OP_CAND_INC: candidate <= candidate + 1'b1;
      kcs_pkg::OP_PUBLISH: begin
        best_coef <= best_coef_reg;
        best_sum  <= best_sum_reg[kcs_pkg::SUM_W-1:0];
      end
      default: ;
    endcase
  end

  assign status.search_ok = search_ok;
  assign status.kind      = kind_reg;
  assign status.dim_last  = dim_idx == dim_last;
  assign status.term_last = term_index == term_count;
  assign status.cand_last = candidate == cand_end;
  assign status.div_busy  = div_busy;

endmodule

### sv/kcs_ctrl.sv
// kcs_ctrl: sequencer for candidates, generators, terms and dimensions
// depends on kcs_pkg; drives kcs_datapath through cmd_t and reads status_t
module kcs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  kcs_pkg::status_t  status,
  output kcs_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_ARED_DIV,
    S_ARED_WAIT,
    S_CAND_FIRST,
    S_GEN_INIT,
    S_GEN_A,
    S_GEN_B,
    S_PP_DIV,
    S_PP_WAIT,
    S_PQ_DIV,
    S_PQ_WAIT,
    S_GEN_NEXT,
    S_MERIT_INIT,
    S_TERM_INIT,
    S_RES,
    S_NUM,
    S_FM_DIV,
    S_FM_WAIT,
    S_MUL_A,
    S_MUL_B,
    S_DIM_NEXT,
    S_SQ_A,
    S_SQ_B,
    S_TERM_NEXT,
    S_CONSIDER,
    S_CAND_NEXT,
    S_FINISH
  } state_t;

  state_t state;
  logic   publish;

  assign in_ready = state == S_IDLE;
  assign publish  = (state == S_FINISH) && (!out_valid || out_ready);

  // operation for the current state
  always_comb begin
    cmd.op = kcs_pkg::OP_NONE;
    case (state)
      S_IDLE:       cmd.op = in_valid ? kcs_pkg::OP_START : kcs_pkg::OP_NONE;
      S_ARED_DIV:   cmd.op = kcs_pkg::OP_DIV_ARED;
      S_ARED_WAIT:  cmd.op = status.div_busy ? kcs_pkg::OP_NONE : kcs_pkg::OP_TAKE_ARED;
      S_CAND_FIRST: cmd.op = kcs_pkg::OP_CAND_FIRST;
      S_GEN_INIT:   cmd.op = kcs_pkg::OP_GEN_INIT;
      S_GEN_A:      cmd.op = kcs_pkg::OP_GEN_A;
      S_GEN_B:      cmd.op = kcs_pkg::OP_GEN_B;
      S_PP_DIV:     cmd.op = kcs_pkg::OP_DIV_PP;
      S_PP_WAIT:    cmd.op = status.div_busy ? kcs_pkg::OP_NONE : kcs_pkg::OP_TAKE_PP;
      S_PQ_DIV:     cmd.op = kcs_pkg::OP_DIV_PQ;
      S_PQ_WAIT:    cmd.op = status.div_busy ? kcs_pkg::OP_NONE : kcs_pkg::OP_TAKE_PQ;
      S_GEN_NEXT:   cmd.op = status.dim_last ? kcs_pkg::OP_NONE : kcs_pkg::OP_J_NEXT;
      S_MERIT_INIT: cmd.op = kcs_pkg::OP_MERIT_INIT;
      S_TERM_INIT:  cmd.op = kcs_pkg::OP_TERM_INIT;
      S_RES:        cmd.op = kcs_pkg::OP_RES;
      S_NUM:        cmd.op = kcs_pkg::OP_NUM;
      S_FM_DIV:     cmd.op = kcs_pkg::OP_DIV_FM;
      S_MUL_A:      cmd.op = status.div_busy ? kcs_pkg::OP_NONE : kcs_pkg::OP_MUL_A;
      S_MUL_B:      cmd.op = kcs_pkg::OP_MUL_B;
      S_DIM_NEXT:   cmd.op = status.dim_last ? kcs_pkg::OP_NONE : kcs_pkg::OP_J_NEXT;
      S_SQ_A:       cmd.op = kcs_pkg::OP_SQ_A;
      S_SQ_B:       cmd.op = kcs_pkg::OP_SQ_B;
      S_TERM_NEXT:  cmd.op = status.term_last ? kcs_pkg::OP_NONE : kcs_pkg::OP_TERM_INC;
      S_CONSIDER:   cmd.op = kcs_pkg::OP_CONSIDER;
      S_CAND_NEXT:  cmd.op = status.cand_last ? kcs_pkg::OP_NONE : kcs_pkg::OP_CAND_INC;
      S_FINISH:     cmd.op = publish ? kcs_pkg::OP_PUBLISH : kcs_pkg::OP_NONE;
      default:      cmd.op = kcs_pkg::OP_NONE;
    endcase
  end

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:       if (in_valid) state <= S_CHECK;
        S_CHECK: begin
          if (!status.search_ok) begin
            state <= S_FINISH;
          end else if (status.kind) begin
            state <= S_ARED_DIV;
          end else begin
            state <= S_CAND_FIRST;
          end
        end
        S_ARED_DIV:   state <= S_ARED_WAIT;
        S_ARED_WAIT:  if (!status.div_busy) state <= S_CAND_FIRST;
        S_CAND_FIRST: state <= S_GEN_INIT;
        S_GEN_INIT:   state <= S_GEN_A;
        S_GEN_A:      state <= status.kind ? S_GEN_B : S_PP_DIV;
        S_GEN_B:      state <= S_PP_DIV;
        S_PP_DIV:     state <= S_PP_WAIT;
        S_PP_WAIT: begin
          if (!status.div_busy) state <= status.kind ? S_PQ_DIV : S_GEN_NEXT;
        end
        S_PQ_DIV:     state <= S_PQ_WAIT;
        S_PQ_WAIT:    if (!status.div_busy) state <= S_GEN_NEXT;
        S_GEN_NEXT:   state <= status.dim_last ? S_MERIT_INIT : S_GEN_A;
        S_MERIT_INIT: state <= S_TERM_INIT;
        S_TERM_INIT:  state <= S_RES;
        S_RES:        state <= S_NUM;
        S_NUM:        state <= S_FM_DIV;
        S_FM_DIV:     state <= S_FM_WAIT;
        S_FM_WAIT:    if (!status.div_busy) state <= S_MUL_A;
        S_MUL_A:      state <= S_MUL_B;
        S_MUL_B:      state <= S_DIM_NEXT;
        S_DIM_NEXT:   state <= status.dim_last ? S_SQ_A : S_RES;
        S_SQ_A:       state <= S_SQ_B;
        S_SQ_B:       state <= S_TERM_NEXT;
        S_TERM_NEXT:  state <= status.term_last ? S_CONSIDER : S_TERM_INIT;
        S_CONSIDER:   state <= S_CAND_NEXT;
        S_CAND_NEXT:  state <= status.cand_last ? S_FINISH : S_GEN_INIT;
        S_FINISH:     if (publish) state <= S_IDLE;
        default:      state <= S_IDLE;
      endcase
    end
  end

endmodule
